// ===== rtl/wsr_pkg.sv =====
// Shared types, constants and command/status structs of the waveform spike remover.
// No dependencies; imported by every other file in rtl/.
package wsr_pkg;

  // Frame geometry and sample format
  localparam int CELLS       = 1024;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int CELL_BITS   = $clog2(CELLS);
  localparam int CNT_BITS    = 3;
  localparam int THR_BITS    = 12;
  localparam int CFG_BITS    = 2;
  // sweep counter covers the longest pass plus its drain cycles
  localparam int KW          = $clog2(CELLS + 5);
  // above this many channels the medium threshold confirms
  localparam int CONF_SPLIT  = 3;

  // Register reset values, 0.1 mV units
  localparam logic [THR_BITS-1:0] LOW_RST    = THR_BITS'(50);
  localparam logic [THR_BITS-1:0] MEDIUM_RST = THR_BITS'(75);
  localparam logic [THR_BITS-1:0] HIGH_RST   = THR_BITS'(100);
  localparam logic [THR_BITS-1:0] STEP_RST   = THR_BITS'(148);

  typedef enum logic [CFG_BITS-1:0] {
    REG_LOW, REG_MEDIUM, REG_HIGH, REG_STEP
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD, REQ_READ
  } req_e;

  typedef enum logic [1:0] {
    PASS_IDLE, PASS_DETECT, PASS_CORRECT, PASS_SMOOTH
  } pass_e;

  // one cell: all lanes packed, lane 0 in the low bits
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cell_vec_t;

  // controller -> datapath: sweep command for this cycle
  typedef struct packed {
    logic            issue;
    pass_e           pass;
    logic [KW-1:0]   k;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_go;
  } stat_t;

endpackage

// ===== rtl/wsr_ctrl.sv =====
// Pass sequencer of the waveform spike remover: detect, correct, smooth sweeps.
// Depends on wsr_pkg.
module wsr_ctrl import wsr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  // last issuing step and last step (end of drain) of each pass
  localparam logic [KW-1:0] DET_LAST = KW'(CELLS + 2);
  localparam logic [KW-1:0] DET_END  = KW'(CELLS + 4);
  localparam logic [KW-1:0] COR_LAST = KW'(CELLS);
  localparam logic [KW-1:0] COR_END  = KW'(CELLS + 2);
  localparam logic [KW-1:0] SMO_LAST = KW'(CELLS + 1);
  localparam logic [KW-1:0] SMO_END  = KW'(CELLS + 3);

  pass_e         state_q, state_d;
  logic [KW-1:0] k_q, k_d;
  logic          issue;

  // state and sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PASS_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state and command
  always_comb begin
    state_d = state_q;
    k_d     = k_q + KW'(1);
    issue   = 1'b0;
    case (state_q)
      PASS_IDLE: begin
        k_d = '0;
        if (stat_i.frame_go) state_d = PASS_DETECT;
      end
      PASS_DETECT: begin
        issue = (k_q <= DET_LAST);
        if (k_q == DET_END) begin
          state_d = PASS_CORRECT;
          k_d     = '0;
        end
      end
      PASS_CORRECT: begin
        issue = (k_q <= COR_LAST);
        if (k_q == COR_END) begin
          state_d = PASS_SMOOTH;
          k_d     = '0;
        end
      end
      PASS_SMOOTH: begin
        issue = (k_q <= SMO_LAST);
        if (k_q == SMO_END) begin
          state_d = PASS_IDLE;
          k_d     = '0;
        end
      end
      default: begin
        state_d = PASS_IDLE;
        k_d     = '0;
      end
    endcase
  end

  assign cmd_o.issue = issue;
  assign cmd_o.pass  = state_q;
  assign cmd_o.k     = k_q;
  assign busy_o      = (state_q != PASS_IDLE);

`ifndef SYNTH
  // a frame can only start from idle
  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.frame_go |-> state_q == PASS_IDLE)
    else $error("frame start while busy");
  // detect is entered only after a frame start
  a_det_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == PASS_DETECT && $past(state_q) == PASS_IDLE) |-> $past(stat_i.frame_go))
    else $error("detect pass without frame start");
  // counter never runs past the longest pass
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= DET_END)
    else $error("sweep counter out of range");
`endif

endmodule

// ===== rtl/wsr_dp.sv =====
// Datapath of the waveform spike remover: sample store, mark stores, window
// registers, detection, correction and smoothing logic. Depends on wsr_pkg.
module wsr_dp import wsr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  acc_i,
  input  logic                  req_type_i,
  input  logic [CELL_BITS-1:0]  cell_index_i,
  input  logic [CELL_BITS-1:0]  trigger_cell_i,
  input  logic [CNT_BITS-1:0]   channel_count_i,
  input  cell_vec_t             load_vec_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_BITS-1:0]   cfg_idx_i,
  input  logic [THR_BITS-1:0]   cfg_wdata_i,
  output logic                  done_o,
  output logic [CELL_BITS-1:0]  read_cell_o,
  output cell_vec_t             read_vec_o
);

  localparam int EXT = SAMPLE_BITS + 2;
  localparam logic signed [EXT-1:0] SAT_HI = EXT'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [EXT-1:0] SAT_LO = EXT'(-(1 << (SAMPLE_BITS - 1)));

  // sign * (a - b) > thr, sign given as "positive step"
  function automatic logic step_ok(input logic pos,
                                   input logic signed [SAMPLE_BITS-1:0] a,
                                   input logic signed [SAMPLE_BITS-1:0] b,
                                   input logic [THR_BITS-1:0] thr);
    logic signed [SAMPLE_BITS:0] ax;
    logic signed [SAMPLE_BITS:0] bx;
    logic signed [SAMPLE_BITS:0] d;
    ax = (SAMPLE_BITS+1)'(a);
    bx = (SAMPLE_BITS+1)'(b);
    d  = pos ? (ax - bx) : (bx - ax);
    return d > $signed((SAMPLE_BITS+1)'(thr));
  endfunction

  // step at w1 against w0 and step at w2 against w3
  function automatic logic pair_ok(input logic pos,
                                   input logic [SAMPLE_BITS-1:0] w0,
                                   input logic [SAMPLE_BITS-1:0] w1,
                                   input logic [SAMPLE_BITS-1:0] w2,
                                   input logic [SAMPLE_BITS-1:0] w3,
                                   input logic [THR_BITS-1:0] thr);
    return step_ok(pos, w1, w0, thr) && step_ok(pos, w2, w3, thr);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [EXT-1:0] v);
    logic signed [EXT-1:0] r;
    r = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return r[SAMPLE_BITS-1:0];
  endfunction

  // mark entry {valid, positive} as a signed count
  function automatic logic signed [2:0] mval(input logic [1:0] m);
    return m[1] ? (m[0] ? 3'sd1 : -3'sd1) : 3'sd0;
  endfunction

  // configuration and frame registers
  logic [THR_BITS-1:0]  low_q, medium_q, high_q, step_q;
  logic [CELL_BITS-1:0] frame_trig_q;
  logic [CNT_BITS-1:0]  frame_nch_q, nch_in;
  logic                 is_load, is_read;

  assign is_load = acc_i && (req_type_i == REQ_LOAD);
  assign is_read = acc_i && (req_type_i == REQ_READ);
  assign nch_in  = (channel_count_i > CNT_BITS'(CHANNELS)) ? CNT_BITS'(CHANNELS)
                                                          : channel_count_i;
  assign stat_o.frame_go = is_load && (cell_index_i == CELL_BITS'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q        <= LOW_RST;
      medium_q     <= MEDIUM_RST;
      high_q       <= HIGH_RST;
      step_q       <= STEP_RST;
      frame_trig_q <= '0;
      frame_nch_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LOW:    low_q    <= cfg_wdata_i;
          REG_MEDIUM: medium_q <= cfg_wdata_i;
          REG_HIGH:   high_q   <= cfg_wdata_i;
          REG_STEP:   step_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (stat_o.frame_go) begin
        frame_trig_q <= trigger_cell_i;
        frame_nch_q  <= nch_in;
      end
    end
  end

  // command pipeline: s1 = read data ready, s2 = window ready
  cmd_t cmd1_q, cmd2_q;
  logic done_q;
  logic [CELL_BITS-1:0] read_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd1_q <= '0;
      cmd2_q <= '0;
      done_q <= 1'b0;
    end else begin
      cmd1_q <= cmd_i;
      cmd2_q <= cmd1_q;
      done_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) read_cell_q <= cell_index_i;
  end

  // read addresses: forward sweep on port A, mirror sweep on port B
  logic [CELL_BITS-1:0] c2_base, addr_a, addr_b;
  assign c2_base = {~frame_trig_q[CELL_BITS-2:0], 1'b0};
  assign addr_a  = cmd_i.issue ? CELL_BITS'(cmd_i.k - KW'(1)) : cell_index_i;
  assign addr_b  = c2_base + CELL_BITS'(2) - CELL_BITS'(cmd_i.k);

  // sample store
  cell_vec_t            store_mem [CELLS];
  cell_vec_t            rd_a_q, rd_b_q;
  logic                 st_we;
  logic [CELL_BITS-1:0] st_waddr;
  cell_vec_t            st_wdata;
  cell_vec_t            cor_vec, smo_vec;

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= st_wdata;
    rd_a_q <= store_mem[addr_a];
    rd_b_q <= store_mem[addr_b];
  end

  // detection windows: [0]=c-1, [1]=c, [2]=c+1, [3]=c+2
  cell_vec_t win_a_q [4];
  cell_vec_t win_b_q [4];

  always_ff @(posedge clk_i) begin
    if (cmd1_q.issue && cmd1_q.pass == PASS_DETECT) begin
      win_a_q[0] <= win_a_q[1];
      win_a_q[1] <= win_a_q[2];
      win_a_q[2] <= win_a_q[3];
      win_a_q[3] <= rd_a_q;
      win_b_q[3] <= win_b_q[2];
      win_b_q[2] <= win_b_q[1];
      win_b_q[1] <= win_b_q[0];
      win_b_q[0] <= rd_b_q;
    end
  end

  // double spike detection at cell i and its mirror
  logic                pos_det, det, confirm;
  logic [THR_BITS-1:0] conf_thr;

  always_comb begin
    pos_det  = $signed(win_a_q[1][0]) > $signed(win_a_q[0][0]);
    conf_thr = (frame_nch_q > CNT_BITS'(CONF_SPLIT)) ? medium_q : low_q;
    confirm  = 1'b0;
    for (int ch = 1; ch < CHANNELS; ch++) begin
      if (CNT_BITS'(ch) < frame_nch_q) begin
        confirm = confirm ||
          (pair_ok(pos_det, win_a_q[0][ch], win_a_q[1][ch], win_a_q[2][ch],
                   win_a_q[3][ch], conf_thr) &&
           pair_ok(pos_det, win_b_q[0][ch], win_b_q[1][ch], win_b_q[2][ch],
                   win_b_q[3][ch], conf_thr));
      end
    end
    det = (frame_nch_q != '0) &&
          pair_ok(pos_det, win_a_q[0][0], win_a_q[1][0], win_a_q[2][0],
                  win_a_q[3][0], high_q) &&
          pair_ok(pos_det, win_b_q[0][0], win_b_q[1][0], win_b_q[2][0],
                  win_b_q[3][0], low_q) &&
          ((frame_nch_q < CNT_BITS'(2)) || confirm);
  end

  // mark stores: A indexed by cell, B by mirror cell; each cell written once
  logic [1:0]           mark_a_mem [CELLS];
  logic [1:0]           mark_b_mem [CELLS];
  logic [1:0]           mk_a_q, mk_b_q;
  logic                 mk_we;
  logic [CELL_BITS-1:0] mk_i, mk_c2;

  assign mk_we = cmd2_q.issue && (cmd2_q.pass == PASS_DETECT) && (cmd2_q.k >= KW'(3));
  assign mk_i  = CELL_BITS'(cmd2_q.k - KW'(3));
  assign mk_c2 = c2_base - mk_i;

  always_ff @(posedge clk_i) begin
    if (mk_we) begin
      mark_a_mem[mk_i]  <= {det, pos_det};
      mark_b_mem[mk_c2] <= {det, pos_det};
    end
    mk_a_q <= mark_a_mem[addr_a];
    mk_b_q <= mark_b_mem[addr_a];
  end

  // correction: cell j gets corr(j-1) then corr(j); cell 0 gets corr(0) then corr(last)
  logic signed [THR_BITS:0] corr_now, cor_first, cor_second, prev_corr_q, wrap_corr_q;
  logic signed [2:0]        mk_sum;
  logic [SAMPLE_BITS-1:0]   cor_mid;

  always_comb begin
    mk_sum = mval(mk_a_q) + mval(mk_b_q);
    if (!(mk_a_q[1] || mk_b_q[1]))  corr_now = '0;
    else if (mk_sum > 3'sd0)         corr_now = $signed({1'b0, step_q});
    else                             corr_now = -$signed({1'b0, step_q});
    cor_first  = (cmd1_q.k == KW'(1)) ? corr_now : prev_corr_q;
    cor_second = (cmd1_q.k == KW'(1)) ? wrap_corr_q : corr_now;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      cor_mid = sat(EXT'($signed(rd_a_q[ch])) - EXT'(cor_first));
      if (CNT_BITS'(ch) < frame_nch_q)
        cor_vec[ch] = sat(EXT'($signed(cor_mid)) - EXT'(cor_second));
      else
        cor_vec[ch] = rd_a_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd1_q.issue && cmd1_q.pass == PASS_CORRECT) begin
      if (cmd1_q.k == '0) wrap_corr_q <= corr_now;
      else                prev_corr_q <= corr_now;
    end
  end

  // smoothing: a = updated previous, c = center, b = next (from read port)
  cell_vec_t                   sm_a_q, sm_c_q;
  logic                        sm_pos, sm_hit;
  logic signed [SAMPLE_BITS:0] sm_sum;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      sm_pos = $signed(sm_c_q[ch]) > $signed(sm_a_q[ch]);
      sm_hit = step_ok(sm_pos, sm_c_q[ch], sm_a_q[ch], high_q) &&
               step_ok(sm_pos, sm_c_q[ch], rd_a_q[ch], high_q);
      sm_sum = (SAMPLE_BITS+1)'($signed(sm_a_q[ch])) +
               (SAMPLE_BITS+1)'($signed(rd_a_q[ch]));
      if (sm_hit && (CNT_BITS'(ch) < frame_nch_q)) smo_vec[ch] = sm_sum[SAMPLE_BITS:1];
      else                                         smo_vec[ch] = sm_c_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd1_q.issue && cmd1_q.pass == PASS_SMOOTH) begin
      if (cmd1_q.k == '0) begin
        sm_a_q <= rd_a_q;
      end else if (cmd1_q.k == KW'(1)) begin
        sm_c_q <= rd_a_q;
      end else begin
        sm_a_q <= smo_vec;
        sm_c_q <= rd_a_q;
      end
    end
  end

  // sample store write port
  always_comb begin
    st_we    = 1'b0;
    st_waddr = cell_index_i;
    st_wdata = load_vec_i;
    if (is_load) begin
      st_we = 1'b1;
    end else if (cmd1_q.issue && cmd1_q.pass == PASS_CORRECT && cmd1_q.k >= KW'(1)) begin
      st_we    = 1'b1;
      st_waddr = CELL_BITS'(cmd1_q.k - KW'(1));
      st_wdata = cor_vec;
    end else if (cmd1_q.issue && cmd1_q.pass == PASS_SMOOTH && cmd1_q.k >= KW'(2)) begin
      st_we    = 1'b1;
      st_waddr = CELL_BITS'(cmd1_q.k - KW'(2));
      st_wdata = smo_vec;
    end
  end

  assign done_o      = done_q;
  assign read_cell_o = read_cell_q;
  assign read_vec_o  = rd_a_q;

`ifndef SYNTH
  // host loads never collide with sweep write-back
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |-> !cmd1_q.issue && !cmd2_q.issue)
    else $error("load during processing");
  // window stage follows the read stage
  a_s2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd2_q.issue |-> $past(cmd1_q.issue))
    else $error("pipeline stage out of order");
  // latched channel count is saturated
  a_nch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_nch_q <= CNT_BITS'(CHANNELS))
    else $error("channel count above lane count");
`endif

endmodule

// ===== rtl/waveform_spike_remover_top.sv =====
// Top level of the waveform spike remover: command port, config port, results.
// Depends on wsr_pkg, wsr_ctrl and wsr_dp.

// A transaction is taken at each clock edge with start high and busy low, so
// loads and reads go at one per cycle. A load of the last cell (1023) latches
// the trigger cell and channel count and starts processing: three sweeps over
// the sample store (detect, correct, smooth), each one cell per cycle through
// the store's registered read ports, with busy high throughout. A read
// returns its cell on the result ports in the cycle after it is taken,
// marked by done_o for exactly one cycle; the receiver cannot stall, so
// results must be captured as they appear.
module waveform_spike_remover_top import wsr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   req_type_i,
  input  logic [CELL_BITS-1:0]   cell_index_i,
  input  logic [CELL_BITS-1:0]   trigger_cell_i,
  input  logic [CNT_BITS-1:0]    channel_count_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_0_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_1_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_2_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_3_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_BITS-1:0]    cfg_idx_i,
  input  logic [THR_BITS-1:0]    cfg_wdata_i,
  output logic                   done_o,
  output logic [CELL_BITS-1:0]   read_cell_o,
  output logic signed [SAMPLE_BITS-1:0] value_0_o,
  output logic signed [SAMPLE_BITS-1:0] value_1_o,
  output logic signed [SAMPLE_BITS-1:0] value_2_o,
  output logic signed [SAMPLE_BITS-1:0] value_3_o
);

  cmd_t      cmd;
  stat_t     stat;
  logic      acc;
  cell_vec_t load_vec, read_vec;

  // transaction accepted
  assign acc      = start && !busy;
  assign load_vec = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};

  wsr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  wsr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .acc_i           (acc),
    .req_type_i      (req_type_i),
    .cell_index_i    (cell_index_i),
    .trigger_cell_i  (trigger_cell_i),
    .channel_count_i (channel_count_i),
    .load_vec_i      (load_vec),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .read_cell_o     (read_cell_o),
    .read_vec_o      (read_vec)
  );

  // result lanes
  assign value_0_o = read_vec[0];
  assign value_1_o = read_vec[1];
  assign value_2_o = read_vec[2];
  assign value_3_o = read_vec[3];

endmodule
